// ===== hw/rtl/tvp_pkg.sv =====
// Shared types, constants and the control program for the three-way value partition block.
package tvp_pkg;

  localparam int MAX_WORDS_DEF = 64;
  localparam int WORD_BITS_DEF = 32;
  localparam int DATA_BITS     = 32;
  localparam int EXT_BITS      = 64;
  localparam int STEP_BITS     = 4;

  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t S_LOAD   = step_t'(0);
  localparam step_t S_SCAN   = step_t'(1);
  localparam step_t S_CLASS  = step_t'(2);
  localparam step_t S_Z_RD   = step_t'(3);
  localparam step_t S_Z_MOVE = step_t'(4);
  localparam step_t S_Z_PUT  = step_t'(5);
  localparam step_t S_O_RD   = step_t'(6);
  localparam step_t S_O_MOVE = step_t'(7);
  localparam step_t S_O_PUT  = step_t'(8);
  localparam step_t S_E_RD   = step_t'(9);
  localparam step_t S_E_OUT  = step_t'(10);

  typedef enum logic [1:0] {RS_NONE, RS_SCAN, RS_ZB, RS_OB} rsel_t;
  typedef enum logic [1:0] {WR_NONE, WR_SCAN_RD, WR_ZB_TA, WR_OB_TB} wop_t;
  typedef enum logic [1:0] {LT_NONE, LT_BOTH, LT_TB} lat_t;
  typedef enum logic [2:0] {BR_NEXT, BR_GOTO, BR_LOAD, BR_SCAN_END, BR_CLASS, BR_EMIT} br_t;

  typedef struct packed {
    rsel_t rd_sel;
    wop_t  wr_op;
    lat_t  lat;
    logic  inc_scan;
    logic  inc_zb;
    logic  inc_ob;
    br_t   br;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic  store;
    logic  clr_ptrs;
    logic  emit;
    logic  done;
    rsel_t rd_sel;
    wop_t  wr_op;
    lat_t  lat;
    logic  inc_scan;
    logic  inc_zb;
    logic  inc_ob;
  } ctl_t;

  typedef struct packed {
    logic scan_end;
    logic is_one;
    logic is_zero;
    logic emit_last;
    logic out_free;
  } stat_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w.rd_sel   = RS_NONE;
    w.wr_op    = WR_NONE;
    w.lat      = LT_NONE;
    w.inc_scan = 1'b0;
    w.inc_zb   = 1'b0;
    w.inc_ob   = 1'b0;
    w.br       = BR_NEXT;
    w.target   = S_LOAD;
    case (s)
      S_LOAD: begin
        w.br     = BR_LOAD;
        w.target = S_SCAN;
      end
      S_SCAN: begin
        w.rd_sel = RS_SCAN;
        w.br     = BR_SCAN_END;
        w.target = S_E_RD;
      end
      S_CLASS: begin
        w.lat    = LT_BOTH;
        w.br     = BR_CLASS;
        w.target = S_O_RD;
      end
      S_Z_RD: begin
        w.rd_sel = RS_ZB;
      end
      S_Z_MOVE: begin
        w.wr_op = WR_SCAN_RD;
        w.lat   = LT_TB;
      end
      S_Z_PUT: begin
        w.wr_op  = WR_ZB_TA;
        w.inc_zb = 1'b1;
      end
      S_O_RD: begin
        w.rd_sel = RS_OB;
      end
      S_O_MOVE: begin
        w.wr_op = WR_SCAN_RD;
      end
      S_O_PUT: begin
        w.wr_op    = WR_OB_TB;
        w.inc_ob   = 1'b1;
        w.inc_scan = 1'b1;
        w.br       = BR_GOTO;
        w.target   = S_SCAN;
      end
      S_E_RD: begin
        w.rd_sel = RS_SCAN;
      end
      S_E_OUT: begin
        w.br     = BR_EMIT;
        w.target = S_LOAD;
      end
      default: begin
        w.br     = BR_GOTO;
        w.target = S_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/tvp_seq.sv =====
// Microcode sequencer: step counter, control store lookup and branch resolution.
module tvp_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  input  tvp_pkg::stat_t stat,
  output logic          in_ready,
  output tvp_pkg::ctl_t ctl
);
  import tvp_pkg::*;

  step_t  step_r;
  step_t  step_nxt;
  uword_t uw;

  always_comb begin
    uw           = ucode(step_r);
    ctl.store    = 1'b0;
    ctl.clr_ptrs = 1'b0;
    ctl.emit     = 1'b0;
    ctl.done     = 1'b0;
    ctl.rd_sel   = uw.rd_sel;
    ctl.wr_op    = uw.wr_op;
    ctl.lat      = uw.lat;
    ctl.inc_scan = uw.inc_scan;
    ctl.inc_zb   = uw.inc_zb;
    ctl.inc_ob   = uw.inc_ob;
    in_ready     = 1'b0;
    step_nxt     = step_r + step_t'(1);
    unique case (uw.br)
      BR_NEXT: begin
      end
      BR_GOTO: begin
        step_nxt = uw.target;
      end
      BR_LOAD: begin
        in_ready = 1'b1;
        step_nxt = step_r;
        if (in_valid) begin
          ctl.store = 1'b1;
          if (in_last) begin
            ctl.clr_ptrs = 1'b1;
            step_nxt     = uw.target;
          end
        end
      end
      BR_SCAN_END: begin
        if (stat.scan_end) begin
          ctl.rd_sel   = RS_NONE;
          ctl.clr_ptrs = 1'b1;
          step_nxt     = uw.target;
        end
      end
      BR_CLASS: begin
        if (stat.is_one) begin
          step_nxt = uw.target;
        end else if (!stat.is_zero) begin
          ctl.inc_scan = 1'b1;
          step_nxt     = S_SCAN;
        end
      end
      BR_EMIT: begin
        step_nxt = step_r;
        if (stat.out_free) begin
          ctl.emit     = 1'b1;
          ctl.inc_scan = 1'b1;
          if (stat.emit_last) begin
            ctl.done = 1'b1;
            step_nxt = uw.target;
          end else begin
            step_nxt = S_E_RD;
          end
        end
      end
      default: begin
        step_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_LOAD;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== hw/rtl/tvp_dp.sv =====
// Datapath: list buffer memory, scan and boundary pointers, swap temporaries and output register.
module tvp_dp #(
  parameter int MAX_WORDS = tvp_pkg::MAX_WORDS_DEF,
  parameter int WORD_BITS = tvp_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tvp_pkg::ctl_t                ctl,
  input  logic [tvp_pkg::DATA_BITS-1:0] in_data,
  output tvp_pkg::stat_t               stat,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [tvp_pkg::DATA_BITS-1:0] out_data,
  output logic                         out_last,
  output logic                         out_user
);
  import tvp_pkg::*;

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW = $clog2(MAX_WORDS + 1);

  logic [WORD_BITS-1:0] list_buf_r [MAX_WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic [WORD_BITS-1:0] ta_r;
  logic [WORD_BITS-1:0] tb_r;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        scan_r, scan_nxt;
  logic [CW-1:0]        zb_r, zb_nxt;
  logic [CW-1:0]        ob_r, ob_nxt;
  logic                 dropped_r, dropped_nxt;
  logic                 out_valid_r;
  logic [DATA_BITS-1:0] out_data_r;
  logic                 out_last_r;
  logic                 out_user_r;

  logic signed [EXT_BITS-1:0] ext_in;
  logic signed [EXT_BITS-1:0] ext_out;
  logic [WORD_BITS-1:0]       in_word;
  logic                       full;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic                       we;
  logic [AW-1:0]              wr_addr;
  logic [WORD_BITS-1:0]       wdata;

  assign ext_in  = EXT_BITS'(signed'(in_data));
  assign in_word = ext_in[WORD_BITS-1:0];
  assign ext_out = EXT_BITS'(signed'(rdata_r));
  assign full    = (cnt_r >= CW'(MAX_WORDS));

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    unique case (ctl.rd_sel)
      RS_SCAN: rd_addr = scan_r[AW-1:0];
      RS_ZB:   rd_addr = zb_r[AW-1:0];
      RS_OB:   rd_addr = ob_r[AW-1:0];
      default: rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = '0;
    wdata   = in_word;
    if (ctl.store) begin
      we      = !full;
      wr_addr = cnt_r[AW-1:0];
    end else begin
      unique case (ctl.wr_op)
        WR_SCAN_RD: begin
          we      = 1'b1;
          wr_addr = scan_r[AW-1:0];
          wdata   = rdata_r;
        end
        WR_ZB_TA: begin
          we      = 1'b1;
          wr_addr = zb_r[AW-1:0];
          wdata   = ta_r;
        end
        WR_OB_TB: begin
          we      = 1'b1;
          wr_addr = ob_r[AW-1:0];
          wdata   = tb_r;
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      list_buf_r[wr_addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= list_buf_r[rd_addr];
    end
  end

  always_comb begin
    scan_nxt    = scan_r;
    zb_nxt      = zb_r;
    ob_nxt      = ob_r;
    cnt_nxt     = cnt_r;
    dropped_nxt = dropped_r;
    if (ctl.clr_ptrs) begin
      scan_nxt = '0;
      zb_nxt   = '0;
      ob_nxt   = '0;
    end else begin
      if (ctl.inc_scan) scan_nxt = scan_r + CW'(1);
      if (ctl.inc_zb)   zb_nxt   = zb_r + CW'(1);
      if (ctl.inc_ob)   ob_nxt   = ob_r + CW'(1);
    end
    if (ctl.done) begin
      cnt_nxt     = '0;
      dropped_nxt = 1'b0;
    end else if (ctl.store) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= '0;
      zb_r        <= '0;
      ob_r        <= '0;
      cnt_r       <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      scan_r    <= scan_nxt;
      zb_r      <= zb_nxt;
      ob_r      <= ob_nxt;
      cnt_r     <= cnt_nxt;
      dropped_r <= dropped_nxt;
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.lat == LT_BOTH) begin
      ta_r <= rdata_r;
    end
    if (ctl.lat == LT_BOTH || ctl.lat == LT_TB) begin
      tb_r <= rdata_r;
    end
    if (ctl.emit) begin
      out_data_r <= ext_out[DATA_BITS-1:0];
      out_last_r <= stat.emit_last;
      out_user_r <= dropped_r;
    end
  end

  assign stat.scan_end  = (scan_r == cnt_r);
  assign stat.is_one    = (rdata_r == WORD_BITS'(1));
  assign stat.is_zero   = (rdata_r == '0);
  assign stat.emit_last = (({1'b0, scan_r} + (CW + 1)'(1)) == {1'b0, cnt_r});
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;
  assign out_user  = out_user_r;

endmodule

// ===== hw/rtl/three_way_value_partition.sv =====
// Top level of the three-way value partition block: sequencer and datapath.
//
//   Channel | Dir | tdata                 | tlast        | tuser
//   in_     | in  | element_value [31:0]  | is_last      | -
//   out_    | out | result_value [31:0]   | result_last  | overflowed
//
// Loading accepts one beat per cycle. The partition scan runs on the list buffer: a word that
// stays is read and classified; a 1 is also swapped with the word at the one boundary; a 0 is
// rotated through the zero and one boundaries. Output reads and emits each word, waiting while out_ stalls.
// Reset is synchronous and active low and empties the list; the buffer itself is not cleared.
// The input channel is ready only while a list is being loaded.
module three_way_value_partition #(
  parameter int MAX_WORDS = tvp_pkg::MAX_WORDS_DEF,
  parameter int WORD_BITS = tvp_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tvp_pkg::DATA_BITS-1:0] in_tdata,   // [31:0] element_value
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tvp_pkg::DATA_BITS-1:0] out_tdata,  // [31:0] result_value
  output logic                          out_tlast,
  output logic                          out_tuser   // [0] overflowed
);
  import tvp_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  tvp_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .stat     (stat),
    .in_ready (in_tready),
    .ctl      (ctl)
  );

  tvp_dp #(
    .MAX_WORDS (MAX_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_tdata),
    .stat      (stat),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_user  (out_tuser)
  );

endmodule
